>>> hw/rtl/tsd_pkg.sv
// ----------------------------------------------------------------------------
// tsd_pkg
// Types and constants shared by the TURN-over-TCP stream deframer modules.
// ----------------------------------------------------------------------------
package tsd_pkg;

   localparam int unsigned STUN_HEADER_BYTES = 20;
   localparam int unsigned CHAN_HEADER_BYTES = 4;
   localparam int unsigned POS_W             = 17;

   // first header byte thresholds (high byte of 0x4000 and 0x8000)
   localparam logic [7:0] CHAN_TYPE_MIN = 8'h40;
   localparam logic [7:0] BAD_TYPE_MIN  = 8'h80;

   // header byte positions
   localparam logic [POS_W-1:0] HDR_TYPE_HI = POS_W'(0);
   localparam logic [POS_W-1:0] HDR_TYPE_LO = POS_W'(1);
   localparam logic [POS_W-1:0] HDR_LEN_HI  = POS_W'(2);
   localparam logic [POS_W-1:0] HDR_LEN_LO  = POS_W'(3);

   localparam logic FRAME_KIND_STUN = 1'b0;
   localparam logic FRAME_KIND_CHAN = 1'b1;

   typedef struct packed {
      logic       bad_type;
      logic       frame_kind;
      logic       frame_last;
      logic       frame_first;
      logic [7:0] frame_byte;
   } result_type;

endpackage

>>> hw/rtl/tsd_in_reg.sv
// ----------------------------------------------------------------------------
// tsd_in_reg
// Input register: captures one stream byte and holds it until the core
// takes it.
// ----------------------------------------------------------------------------
module tsd_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   output logic       in_valid,
   output logic [7:0] in_byte,
   input  logic       in_take
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       accept;

   assign req_tready = !valid_ff || in_take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (accept) begin
         valid_in = 1'b1;
         byte_in  = req_tdata;
      end else if (in_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule

>>> hw/rtl/tsd_core.sv
// ----------------------------------------------------------------------------
// tsd_core
// Frame tracker: decodes the header, counts body bytes, swallows padding
// and halts on an unknown frame type.
// ----------------------------------------------------------------------------
module tsd_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [7:0]           in_byte,
   output logic                 in_take,
   input  logic                 out_free,
   output logic                 res_load,
   output tsd_pkg::result_type  res
);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_BODY,
      PH_PAD,
      PH_HALT
   } phase_type;

   localparam int unsigned PW = tsd_pkg::POS_W;

   phase_type         phase_ff, phase_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [PW-1:0]     total_ff, total_in;
   logic              kind_ff, kind_in;
   logic [7:0]        len_hi_ff, len_hi_in;
   logic [1:0]        pad_ff, pad_in;

   logic              has_res;
   logic [PW-1:0]     hdr_total;
   logic [PW:0]       pos_next;
   logic [1:0]        hdr_pad;
   logic [1:0]        body_pad;
   logic              kind_now;

   assign hdr_total = PW'({len_hi_ff, in_byte}) +
                      (kind_ff ? PW'(tsd_pkg::CHAN_HEADER_BYTES)
                               : PW'(tsd_pkg::STUN_HEADER_BYTES));
   assign hdr_pad   = 2'd0 - hdr_total[1:0];
   assign body_pad  = 2'd0 - total_ff[1:0];
   assign pos_next  = {1'b0, pos_ff} + (PW+1)'(1);
   assign kind_now  = (in_byte >= tsd_pkg::CHAN_TYPE_MIN);

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      total_in  = total_ff;
      kind_in   = kind_ff;
      len_hi_in = len_hi_ff;
      pad_in    = pad_ff;
      has_res   = 1'b0;
      res       = '{bad_type: 1'b0, frame_kind: kind_ff, frame_last: 1'b0,
                    frame_first: 1'b0, frame_byte: in_byte};
      unique case (phase_ff)
         PH_HALT: begin
            // drop everything until reset
         end
         PH_PAD: begin
            pad_in = pad_ff - 2'd1;
            if (pad_ff == 2'd1) begin
               phase_in = PH_HEADER;
            end
         end
         PH_HEADER: begin
            has_res = 1'b1;
            priority if (pos_ff == tsd_pkg::HDR_TYPE_HI) begin
               if (in_byte >= tsd_pkg::BAD_TYPE_MIN) begin
                  phase_in       = PH_HALT;
                  res.bad_type   = 1'b1;
                  res.frame_kind = tsd_pkg::FRAME_KIND_STUN;
               end else begin
                  kind_in         = kind_now;
                  pos_in          = tsd_pkg::HDR_TYPE_LO;
                  res.frame_first = 1'b1;
                  res.frame_kind  = kind_now;
               end
            end else if (pos_ff == tsd_pkg::HDR_LEN_HI) begin
               len_hi_in = in_byte;
               pos_in    = tsd_pkg::HDR_LEN_LO;
            end else if (pos_ff == tsd_pkg::HDR_LEN_LO) begin
               total_in = hdr_total;
               if (hdr_total <= PW'(tsd_pkg::CHAN_HEADER_BYTES)) begin
                  res.frame_last = 1'b1;
                  pad_in         = hdr_pad;
                  pos_in         = '0;
                  phase_in       = (hdr_pad != 2'd0) ? PH_PAD : PH_HEADER;
               end else begin
                  pos_in   = PW'(tsd_pkg::CHAN_HEADER_BYTES);
                  phase_in = PH_BODY;
               end
            end else begin
               pos_in = pos_next[PW-1:0];
            end
         end
         PH_BODY: begin
            has_res = 1'b1;
            if (pos_next >= {1'b0, total_ff}) begin
               res.frame_last = 1'b1;
               pad_in         = body_pad;
               pos_in         = '0;
               phase_in       = (body_pad != 2'd0) ? PH_PAD : PH_HEADER;
            end else begin
               pos_in = pos_next[PW-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   assign in_take  = in_valid && (!has_res || out_free);
   assign res_load = in_take && has_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         pos_ff    <= '0;
         total_ff  <= '0;
         kind_ff   <= 1'b0;
         len_hi_ff <= '0;
         pad_ff    <= '0;
      end else if (in_take) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         total_ff  <= total_in;
         kind_ff   <= kind_in;
         len_hi_ff <= len_hi_in;
         pad_ff    <= pad_in;
      end
   end

endmodule

>>> hw/rtl/tsd_out_reg.sv
// ----------------------------------------------------------------------------
// tsd_out_reg
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module tsd_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                res_load,
   input  tsd_pkg::result_type res,
   output logic                out_free,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast,
   output logic [2:0]          rsp_tuser
);

   logic                valid_ff, valid_in;
   tsd_pkg::result_type res_ff, res_in;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (res_load) begin
         valid_in = 1'b1;
         res_in   = res;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = res_ff.frame_byte;
   assign rsp_tlast  = res_ff.frame_last;
   assign rsp_tuser  = {res_ff.bad_type, res_ff.frame_kind, res_ff.frame_first};

endmodule

>>> hw/rtl/turn_tcp_stream_deframer_unit.sv
// Data path: input register, then the combinational core, then the result register that drives rsp_.
// Throughput: one byte per cycle; the core consumes the input register
// whenever the result register is empty or being drained.
// Pad bytes and bytes after a bad frame type are consumed and give no result.
// Reset: synchronous, active high; clears the frame state to header phase and
// empties both registers.
// ----------------------------------------------------------------------------
// turn_tcp_stream_deframer_unit
// Splits a TCP byte stream into STUN messages and ChannelData frames.
// ----------------------------------------------------------------------------
module turn_tcp_stream_deframer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] stream_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] frame_byte
   output logic       rsp_tlast,
   output logic [2:0] rsp_tuser    // [0] frame_first, [1] frame_kind, [2] bad_type
);

   logic                in_valid;
   logic [7:0]          in_byte;
   logic                in_take;
   logic                out_free;
   logic                res_load;
   tsd_pkg::result_type res;

   tsd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .in_valid   (in_valid),
      .in_byte    (in_byte),
      .in_take    (in_take)
   );

   tsd_core u_core (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .in_byte  (in_byte),
      .in_take  (in_take),
      .out_free (out_free),
      .res_load (res_load),
      .res      (res)
   );

   tsd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .res_load   (res_load),
      .res        (res),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> hw/rtl/tsd_checker.sv
// ----------------------------------------------------------------------------
// tsd_checker
// Port-level checks for the stream deframer, bound to the top level.
// ----------------------------------------------------------------------------
module tsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [2:0] rsp_tuser
);

   logic rsp_acc;
   logic want_first_ff, want_first_in;

   assign rsp_acc = rsp_tvalid && rsp_tready;

   // a normal result opens a frame exactly after a last byte
   always_comb begin
      want_first_in = want_first_ff;
      if (rsp_acc && !rsp_tuser[2]) begin
         want_first_in = rsp_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         want_first_ff <= 1'b1;
      end else begin
         want_first_ff <= want_first_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result transaction changed");

   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> !rsp_tlast && rsp_tuser[1:0] == 2'b00)
      else $error("bad type result carries frame marks");

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && rsp_tuser[2] |=> !rsp_tvalid)
      else $error("result after bad type");

   a_frame_order: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && !rsp_tuser[2] |-> rsp_tuser[0] == want_first_ff)
      else $error("frame first mark out of order");

   a_bad_at_start: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && rsp_tuser[2] |-> want_first_ff && rsp_tdata[7])
      else $error("bad type flagged inside a frame");

endmodule

bind turn_tcp_stream_deframer_unit tsd_checker u_tsd_checker (.*);
